// ===== rtl/frm_pkg.sv =====
// Shared types and constants for the frame rate monitor.
// Used by frm_div and frame_rate_monitor_unit; no dependencies.
`default_nettype none

package frm_pkg;

    localparam int unsigned RING_DEPTH_DEF = 64;

    localparam int unsigned STAMP_W   = 64;
    localparam int unsigned INST_W    = 28;
    localparam int unsigned AVG_W     = 34;
    localparam int unsigned FRAMES_W  = 7;
    localparam int unsigned WINDOW_W  = 32;
    localparam int unsigned BASE_W    = 28;
    localparam int unsigned TOL_W     = 10;
    localparam int unsigned SCALE_W   = 28;
    localparam int unsigned PCT_W     = 11;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned M_TDATA_W  = 72;

    localparam logic [SCALE_W-1:0]  RATE_SCALE_Q8 = 28'd256000000;
    localparam logic [AVG_W-1:0]    AVERAGE_MAX   = 34'h3_FFFF_FFFF;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX    = 7'd127;
    localparam logic [PCT_W-1:0]    PCT_FULL      = 11'd100;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000000;
    localparam logic [TOL_W-1:0]    TOL_RESET    = 10'd10;

    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_BASE   = 2'd1,
        REG_TOL    = 2'd2,
        REG_JUDGE  = 2'd3
    } reg_idx_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/frm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module frm_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/frm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on frm_pkg for the divisor width and the status struct.
`default_nettype none

module frm_div #(
    parameter int unsigned NUM_W = 35
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [NUM_W-1:0]          num,
    input  wire logic [frm_pkg::STAMP_W-1:0] den,
    output logic      [NUM_W-1:0]          quotient,
    output frm_pkg::div_stat_t             stat
);
    import frm_pkg::*;

    localparam int unsigned BIT_W = $clog2(NUM_W + 1);

    logic [STAMP_W-1:0] rem_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [BIT_W-1:0]   bit_cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [STAMP_W:0]   trial;
    logic [STAMP_W:0]   diff;
    logic               fits;

    // Shift the next numerator bit into the partial remainder and try the subtract.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= BIT_W'(NUM_W);
            end else if (busy_reg) begin
                bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/frame_rate_monitor_unit.sv =====
// Frame rate monitor top level: APB registers, stamp ring, sequencer.
// Depends on frm_pkg, frm_ram and frm_div.
//
//  Port group   Dir   Beat payload (low bit first)
//  s_*          in    stamp_us[63:0]
//  m_*          out   instant_rate_q8[27:0], average_rate_q8[61:28],
//                     frames_in_window[68:62], rate_abnormal[69], zero pad
//  APB          in    window_us, base_rate_q8, tolerance_pct, judge_on_average
//
// The time from one accepted beat to the next grows with NUM_W and with E, the number of
// stamps evicted, where NUM_W = 28 + clog2(RING_DEPTH+1). Each division is skipped for a
// zero divisor; the interval steps are skipped with fewer than two stamps.
// The bit-serial divider, run at most twice per stamp, and the single read port of the
// ring memory set that time. s_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next stamp is taken.
// Reset is synchronous; the ring contents are not cleared, only head and count.
`default_nettype none

module frame_rate_monitor_unit #(
    parameter int unsigned RING_DEPTH = frm_pkg::RING_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // stamp_us[63:0]
    input  wire logic [frm_pkg::STAMP_W-1:0]      s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // instant_rate_q8[27:0], average_rate_q8[61:28], frames_in_window[68:62],
    // rate_abnormal[69], zero [71:70]
    output logic      [frm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [frm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [frm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [frm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import frm_pkg::*;

    localparam int unsigned PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int unsigned NUM_W   = SCALE_W + CNT_W;
    localparam int unsigned MUL_B_W = (CNT_W > PCT_W) ? CNT_W : PCT_W;
    localparam int unsigned PROD_W  = SCALE_W + MUL_B_W;
    localparam int unsigned LHS_W   = AVG_W + 7;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_START     = 16'h0002,
        S_WRITE     = 16'h0004,
        S_EV_RD     = 16'h0008,
        S_EV_CMP    = 16'h0010,
        S_PREV_RD   = 16'h0020,
        S_PREV_CAP  = 16'h0040,
        S_INST_GO   = 16'h0080,
        S_INST_WAIT = 16'h0100,
        S_AVG_PREP  = 16'h0200,
        S_AVG_GO    = 16'h0400,
        S_AVG_WAIT  = 16'h0800,
        S_MUL_LO    = 16'h1000,
        S_MUL_HI    = 16'h2000,
        S_JUDGE     = 16'h4000,
        S_OUT       = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [WINDOW_W-1:0] window_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic                judge_reg;
    logic                cfg_write;

    // Ring bookkeeping.
    logic [PTR_W-1:0]    head_reg;
    logic [CNT_W-1:0]    count_reg;

    // Per-stamp working registers.
    logic [STAMP_W-1:0]  stamp_reg;
    logic [STAMP_W-1:0]  start_reg;
    logic [STAMP_W-1:0]  oldest_reg;
    logic [STAMP_W-1:0]  den_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [INST_W-1:0]   inst_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [LHS_W-1:0]    lhs_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                low_reg;
    logic                abnormal_reg;
    logic [FRAMES_W-1:0] frames;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;
    logic                 out_free;

    // Ring memory ports.
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [PTR_W-1:0]    ram_raddr;
    logic [STAMP_W-1:0]  ram_rdata;

    // Shared multiplier.
    logic [SCALE_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;

    // Shared divider.
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [NUM_W-1:0]    div_quo;
    div_stat_t           div_stat;

    logic [AVG_W-1:0]    judged;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
            sum = sum - (CNT_W+1)'(RING_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            base_reg   <= '0;
            tol_reg    <= TOL_RESET;
            judge_reg  <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_WINDOW: window_reg <= pwdata[WINDOW_W-1:0];
                REG_BASE:   base_reg   <= pwdata[BASE_W-1:0];
                REG_TOL:    tol_reg    <= pwdata[TOL_W-1:0];
                REG_JUDGE:  judge_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WINDOW: prdata = APB_DATA_W'(window_reg);
            REG_BASE:   prdata = APB_DATA_W'(base_reg);
            REG_TOL:    prdata = APB_DATA_W'(tol_reg);
            REG_JUDGE:  prdata = APB_DATA_W'(judge_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- Ring memory ----------------
    frm_ram #(
        .WIDTH  (STAMP_W),
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (stamp_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign ram_we    = (state_reg == S_WRITE);
    assign ram_waddr = ring_add(head_reg, count_reg);
    assign ram_raddr = (state_reg == S_PREV_RD) ? ring_add(head_reg, count_reg - CNT_W'(2))
                                                : head_reg;

    // ---------------- Shared multiplier ----------------
    always_comb begin
        mul_a = base_reg;
        mul_b = MUL_B_W'(PCT_FULL + PCT_W'(tol_reg));
        case (state_reg)
            S_AVG_PREP: begin
                mul_a = RATE_SCALE_Q8;
                mul_b = MUL_B_W'(count_reg);
            end
            S_MUL_LO: begin
                // Only meaningful below 100 percent; the low check is off otherwise.
                mul_b = (tol_reg < TOL_W'(PCT_FULL)) ?
                        MUL_B_W'(PCT_FULL - PCT_W'(tol_reg)) : '0;
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ---------------- Shared divider ----------------
    assign div_start = ((state_reg == S_INST_GO) || (state_reg == S_AVG_GO)) &&
                       (den_reg != '0);
    assign div_num   = (state_reg == S_AVG_GO) ? num_reg : NUM_W'(RATE_SCALE_Q8);

    frm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (den_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ---------------- Sequencer ----------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_START;
            S_START:     state_next = S_WRITE;
            S_WRITE:     state_next = S_EV_RD;
            S_EV_RD:     state_next = S_EV_CMP;
            S_EV_CMP: begin
                if (ram_rdata < start_reg) begin
                    state_next = S_EV_RD;
                end else if (count_reg >= CNT_W'(2)) begin
                    state_next = S_PREV_RD;
                end else begin
                    state_next = S_AVG_PREP;
                end
            end
            S_PREV_RD:   state_next = S_PREV_CAP;
            S_PREV_CAP:  state_next = S_INST_GO;
            S_INST_GO:   state_next = (den_reg != '0) ? S_INST_WAIT : S_AVG_PREP;
            S_INST_WAIT: if (div_stat.done) state_next = S_AVG_PREP;
            S_AVG_PREP:  state_next = S_AVG_GO;
            S_AVG_GO:    state_next = (den_reg != '0) ? S_AVG_WAIT : S_MUL_LO;
            S_AVG_WAIT:  if (div_stat.done) state_next = S_MUL_LO;
            S_MUL_LO:    state_next = S_MUL_HI;
            S_MUL_HI:    state_next = S_JUDGE;
            S_JUDGE:     state_next = S_OUT;
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_START: begin
                    // Full ring: drop the oldest stamp to make room.
                    if (count_reg == CNT_W'(RING_DEPTH)) begin
                        head_reg  <= ring_add(head_reg, CNT_W'(1));
                        count_reg <= CNT_W'(RING_DEPTH - 1);
                    end
                end
                S_WRITE: count_reg <= count_reg + CNT_W'(1);
                S_EV_CMP: begin
                    if (ram_rdata < start_reg) begin
                        head_reg  <= ring_add(head_reg, CNT_W'(1));
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign judged = judge_reg ? avg_reg : AVG_W'(inst_reg);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                stamp_reg <= s_tdata;
                inst_reg  <= '0;
                avg_reg   <= '0;
            end
            S_START: begin
                start_reg <= (stamp_reg >= STAMP_W'(window_reg)) ?
                             stamp_reg - STAMP_W'(window_reg) : '0;
            end
            S_EV_CMP: oldest_reg <= ram_rdata;
            S_PREV_CAP: den_reg <= stamp_reg - ram_rdata;
            S_INST_WAIT: begin
                if (div_stat.done) begin
                    inst_reg <= INST_W'(div_quo);
                end
            end
            S_AVG_PREP: begin
                den_reg <= stamp_reg - oldest_reg;
                num_reg <= NUM_W'(mul_p);
            end
            S_AVG_WAIT: begin
                if (div_stat.done) begin
                    avg_reg <= (64'(div_quo) > 64'(AVERAGE_MAX)) ? AVERAGE_MAX
                                                                  : AVG_W'(div_quo);
                end
            end
            S_MUL_LO: begin
                lhs_reg  <= LHS_W'(judged) * LHS_W'(PCT_FULL);
                prod_reg <= mul_p;
            end
            S_MUL_HI: begin
                low_reg  <= (tol_reg < TOL_W'(PCT_FULL)) &&
                            (64'(lhs_reg) < 64'(prod_reg));
                prod_reg <= mul_p;
            end
            S_JUDGE: begin
                abnormal_reg <= (base_reg != '0) &&
                                (low_reg || (64'(lhs_reg) > 64'(prod_reg)));
            end
            default: ;
        endcase
    end

    assign frames = (32'(count_reg) > 32'(FRAMES_MAX)) ? FRAMES_MAX : FRAMES_W'(count_reg);

    // ---------------- Output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            m_tdata_reg <= {2'b00, abnormal_reg, frames, avg_reg, inst_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("ring count above depth");

    a_newest_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AVG_PREP) |-> (count_reg != '0))
        else $error("eviction removed the newest stamp");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (den_reg != '0))
        else $error("divider started with a zero divisor");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> ((state_reg == S_INST_WAIT) || (state_reg == S_AVG_WAIT)))
        else $error("divider finished while nobody waited");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output state");
`endif

endmodule

`default_nettype wire
